// ===== rtl/core/tvc_pkg.sv =====
// ----------------------------------------------------------------------------
// Terrain viewshed counter package
// Shared types, codes and constants of the viewshed counter.
// ----------------------------------------------------------------------------
package tvc_pkg;

    localparam int MAX_COLS_DEF = 256;
    localparam int MAX_ROWS_DEF = 256;

    localparam int COORD_W  = 10;
    localparam int ALT_W    = 16;
    localparam int CNT_W    = 32;
    localparam int CFG_W    = 9;
    localparam int CFG_IDX_W = 2;
    localparam int SQ_W     = 36;
    localparam int Q_W      = 18;
    localparam int QUO_W    = 40;
    localparam int LH_W     = 42;
    localparam int P_W      = 12;
    localparam int ITER_W   = 6;
    localparam int SQRT_ITERS = 18;

    localparam logic [CFG_W-1:0] GRID_COLS_RST   = 9'd256;
    localparam logic [CFG_W-1:0] GRID_ROWS_RST   = 9'd256;
    localparam logic [7:0]       VIEW_RADIUS_RST = 8'd100;

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VIEW_RADIUS = 2'd2;

    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_SWEEP = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_SW_START, S_OBS_RD, S_OBS_WAIT, S_SCAN, S_TGT_WAIT,
        S_SQ_INIT, S_SQRT, S_DIV_INIT, S_DIV, S_WALK_INIT, S_WALK_CHECK,
        S_WALK_RD, S_WALK_CMP, S_COL_NEXT, S_B_RD_OBS, S_B_WR_OBS, S_B_RD_TGT,
        S_B_WR_TGT, S_RD_WAIT, S_RESP
    } t_state;

    typedef enum logic [4:0] {
        C_NOP, C_ACCEPT, C_CLEAR, C_SW_START, C_OBS_RD, C_OBS_LATCH, C_ROW_NEXT,
        C_TGT_RD, C_TGT_LATCH, C_SQ_INIT, C_SQ_STEP, C_DIV_INIT, C_DIV_STEP,
        C_WALK_INIT, C_STEP, C_WALK_RD, C_COL_NEXT, C_CNT_RD_OBS, C_CNT_WR_OBS,
        C_CNT_RD_TGT, C_CNT_WR_TGT, C_RD_LATCH, C_OUT_LOAD
    } t_dp_cmd;

    typedef struct packed {
        logic clr_last;
        logic obs_in;
        logic row_done;
        logic col_done;
        logic sq_last;
        logic div_last;
        logic walk_end;
        logic blocked;
        logic out_free;
    } t_dp_stat;

endpackage

// ===== rtl/core/tvc_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tvc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== rtl/core/tvc_ctrl.sv =====
// ----------------------------------------------------------------------------
// Viewshed controller
// Sequences the clearing pass, commands, window scan, line walk and updates.
// ----------------------------------------------------------------------------
module tvc_ctrl
    import tvc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic [1:0] i_command,
    output logic      o_in_stall,
    input  t_dp_stat  i_stat,
    output t_dp_cmd   o_cmd
);
    t_state r_state;
    t_state n_state;
    logic   accept;

    assign o_in_stall = (r_state != S_IDLE);
    assign accept     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR:      if (i_stat.clr_last) n_state = S_IDLE;
            S_IDLE: begin
                if (accept && i_command == CMD_SWEEP) begin
                    n_state = S_SW_START;
                end else if (accept && i_command == CMD_READ) begin
                    n_state = S_RD_WAIT;
                end
            end
            S_SW_START:   n_state = i_stat.obs_in ? S_OBS_RD : S_RESP;
            S_OBS_RD:     n_state = S_OBS_WAIT;
            S_OBS_WAIT:   n_state = S_SCAN;
            S_SCAN: begin
                if (i_stat.row_done) begin
                    n_state = S_RESP;
                end else if (!i_stat.col_done) begin
                    n_state = S_TGT_WAIT;
                end
            end
            S_TGT_WAIT:   n_state = S_SQ_INIT;
            S_SQ_INIT:    n_state = S_SQRT;
            S_SQRT:       if (i_stat.sq_last) n_state = S_DIV_INIT;
            S_DIV_INIT:   n_state = S_DIV;
            S_DIV:        if (i_stat.div_last) n_state = S_WALK_INIT;
            S_WALK_INIT:  n_state = S_WALK_CHECK;
            S_WALK_CHECK: n_state = i_stat.walk_end ? S_B_RD_OBS : S_WALK_RD;
            S_WALK_RD:    n_state = S_WALK_CMP;
            S_WALK_CMP:   n_state = i_stat.blocked ? S_COL_NEXT : S_WALK_CHECK;
            S_COL_NEXT:   n_state = S_SCAN;
            S_B_RD_OBS:   n_state = S_B_WR_OBS;
            S_B_WR_OBS:   n_state = S_B_RD_TGT;
            S_B_RD_TGT:   n_state = S_B_WR_TGT;
            S_B_WR_TGT:   n_state = S_COL_NEXT;
            S_RD_WAIT:    n_state = S_RESP;
            S_RESP:       if (i_stat.out_free) n_state = S_IDLE;
            default:      n_state = S_CLEAR;
        endcase
    end

    always_comb begin
        o_cmd = C_NOP;
        unique case (r_state)
            S_CLEAR:      o_cmd = C_CLEAR;
            S_IDLE:       o_cmd = accept ? C_ACCEPT : C_NOP;
            S_SW_START:   o_cmd = C_SW_START;
            S_OBS_RD:     o_cmd = C_OBS_RD;
            S_OBS_WAIT:   o_cmd = C_OBS_LATCH;
            S_SCAN: begin
                if (i_stat.row_done) begin
                    o_cmd = C_NOP;
                end else if (i_stat.col_done) begin
                    o_cmd = C_ROW_NEXT;
                end else begin
                    o_cmd = C_TGT_RD;
                end
            end
            S_TGT_WAIT:   o_cmd = C_TGT_LATCH;
            S_SQ_INIT:    o_cmd = C_SQ_INIT;
            S_SQRT:       o_cmd = C_SQ_STEP;
            S_DIV_INIT:   o_cmd = C_DIV_INIT;
            S_DIV:        o_cmd = C_DIV_STEP;
            S_WALK_INIT:  o_cmd = C_WALK_INIT;
            S_WALK_CHECK: o_cmd = i_stat.walk_end ? C_NOP : C_STEP;
            S_WALK_RD:    o_cmd = C_WALK_RD;
            S_WALK_CMP:   o_cmd = C_NOP;
            S_COL_NEXT:   o_cmd = C_COL_NEXT;
            S_B_RD_OBS:   o_cmd = C_CNT_RD_OBS;
            S_B_WR_OBS:   o_cmd = C_CNT_WR_OBS;
            S_B_RD_TGT:   o_cmd = C_CNT_RD_TGT;
            S_B_WR_TGT:   o_cmd = C_CNT_WR_TGT;
            S_RD_WAIT:    o_cmd = C_RD_LATCH;
            S_RESP:       o_cmd = i_stat.out_free ? C_OUT_LOAD : C_NOP;
            default:      o_cmd = C_NOP;
        endcase
    end
endmodule

// ===== rtl/core/tvc_dp.sv =====
// ----------------------------------------------------------------------------
// Viewshed datapath
// Stores, window scan, square root, slope divider, line walk and count update.
// ----------------------------------------------------------------------------
module tvc_dp
    import tvc_pkg::*;
#(
    parameter int MAX_COLS = MAX_COLS_DEF,
    parameter int MAX_ROWS = MAX_ROWS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic [1:0]           i_command,
    input  logic [7:0]           i_col,
    input  logic [7:0]           i_row,
    input  logic [ALT_W-1:0]     i_altitude,
    input  logic                 i_out_stall,
    output logic                 o_out_valid,
    output logic                 o_kind,
    output logic [CNT_W-1:0]     o_count,
    input  t_dp_cmd              i_cmd,
    output t_dp_stat             o_stat
);
    localparam int DEPTH = MAX_COLS * MAX_ROWS;
    localparam int AW    = $clog2(DEPTH);
    localparam int DIM_W = 14;

    function automatic logic [AW-1:0] cell_addr(input logic [COORD_W-1:0] x,
                                                input logic [COORD_W-1:0] y);
        return AW'(32'(y) * 32'(MAX_COLS) + 32'(x));
    endfunction

    logic [CFG_W-1:0]   r_grid_cols;
    logic [CFG_W-1:0]   r_grid_rows;
    logic [7:0]         r_radius;

    logic [7:0]         r_c0;
    logic [7:0]         r_r0;
    logic               r_in_inside;
    logic               r_resp_kind;
    logic [CNT_W-1:0]   r_resp_cnt;
    logic [AW-1:0]      r_clr;

    logic [COORD_W-1:0] r_x;
    logic [COORD_W-1:0] r_y;
    logic [COORD_W-1:0] r_xs;
    logic [COORD_W-1:0] r_xe;
    logic [COORD_W-1:0] r_yend;
    logic [ALT_W-1:0]   r_a0;

    logic [7:0]         r_major;
    logic [7:0]         r_minor;
    logic               r_xmaj;
    logic               r_sx_neg;
    logic               r_sy_neg;
    logic               r_neg;
    logic [ALT_W-1:0]   r_mag;

    logic [SQ_W-1:0]    r_sq_v;
    logic [SQ_W-1:0]    r_sq_res;
    logic [SQ_W-1:0]    r_sq_bit;
    logic [ITER_W-1:0]  r_iter;
    logic [Q_W-1:0]     r_q;
    logic [QUO_W-1:0]   r_dq;
    logic [Q_W:0]       r_rem;

    logic signed [LH_W-1:0] r_slope;
    logic signed [LH_W-1:0] r_lh;
    logic signed [P_W-1:0]  r_p;
    logic [7:0]             r_i;
    logic [COORD_W-1:0]     r_wx;
    logic [COORD_W-1:0]     r_wy;

    logic [CFG_W-1:0]   cols_lim;
    logic [CFG_W-1:0]   rows_lim;
    logic               in_inside;
    logic [AW-1:0]      in_addr;
    logic [AW-1:0]      obs_addr;
    logic [AW-1:0]      tgt_addr;
    logic [AW-1:0]      walk_addr;

    logic               alt_we;
    logic [AW-1:0]      alt_raddr;
    logic [ALT_W-1:0]   alt_rdata;
    logic               cnt_we;
    logic [AW-1:0]      cnt_waddr;
    logic [CNT_W-1:0]   cnt_wdata;
    logic [AW-1:0]      cnt_raddr;
    logic [CNT_W-1:0]   cnt_rdata;

    logic signed [COORD_W:0] dx;
    logic signed [COORD_W:0] dy;
    logic [7:0]         ax;
    logic [7:0]         ay;
    logic signed [ALT_W:0] rise;
    logic [SQ_W-1:0]    sq_try;
    logic [Q_W:0]       div_sh;
    logic [COORD_W:0]   r0_plus;
    logic [COORD_W:0]   c0_plus;
    logic signed [LH_W-1:0] wall;

    assign cols_lim = (DIM_W'(r_grid_cols) < DIM_W'(MAX_COLS)) ? r_grid_cols
                                                                 : CFG_W'(MAX_COLS);
    assign rows_lim = (DIM_W'(r_grid_rows) < DIM_W'(MAX_ROWS)) ? r_grid_rows
                                                                 : CFG_W'(MAX_ROWS);
    assign in_inside = (DIM_W'(i_col) < DIM_W'(MAX_COLS))
                    && (DIM_W'(i_row) < DIM_W'(MAX_ROWS));
    assign in_addr   = cell_addr(COORD_W'(i_col), COORD_W'(i_row));
    assign obs_addr  = cell_addr(COORD_W'(r_c0), COORD_W'(r_r0));
    assign tgt_addr  = cell_addr(r_x, r_y);
    assign walk_addr = cell_addr(r_wx, r_wy);

    assign dx   = $signed({1'b0, r_x}) - $signed((COORD_W+1)'(r_c0));
    assign dy   = $signed({1'b0, r_y}) - $signed((COORD_W+1)'(r_r0));
    assign ax   = 8'(dx < 0 ? -dx : dx);
    assign ay   = 8'(dy < 0 ? -dy : dy);
    assign rise = $signed({1'b0, alt_rdata}) - $signed({1'b0, r_a0});
    assign sq_try = r_sq_res + r_sq_bit;
    assign div_sh = {r_rem[Q_W-1:0], r_dq[QUO_W-1]};
    assign r0_plus = (COORD_W+1)'(r_r0) + (COORD_W+1)'(r_radius);
    assign c0_plus = (COORD_W+1)'(r_c0) + (COORD_W+1)'(r_radius) + 1'b1;
    assign wall = $signed({(LH_W-ALT_W-16)'(0), alt_rdata, 16'd0});

    assign alt_we = (i_cmd == C_ACCEPT) && (i_command == CMD_LOAD) && in_inside;

    always_comb begin
        unique case (i_cmd)
            C_OBS_RD:  alt_raddr = obs_addr;
            C_WALK_RD: alt_raddr = walk_addr;
            default:   alt_raddr = tgt_addr;
        endcase
    end

    always_comb begin
        cnt_we    = 1'b0;
        cnt_waddr = tgt_addr;
        cnt_wdata = (cnt_rdata == '1) ? cnt_rdata : cnt_rdata + 1'b1;
        cnt_raddr = tgt_addr;
        case (i_cmd)
            C_CLEAR: begin
                cnt_we    = 1'b1;
                cnt_waddr = r_clr;
                cnt_wdata = '0;
            end
            C_CNT_WR_OBS: begin
                cnt_we    = 1'b1;
                cnt_waddr = obs_addr;
            end
            C_CNT_WR_TGT: cnt_we = 1'b1;
            C_ACCEPT:     cnt_raddr = in_addr;
            C_CNT_RD_OBS: cnt_raddr = obs_addr;
            default:      cnt_raddr = tgt_addr;
        endcase
    end

    tvc_ram #(.WIDTH(ALT_W), .DEPTH(DEPTH)) u_alt_ram (
        .i_clk   (i_clk),
        .i_we    (alt_we),
        .i_waddr (in_addr),
        .i_wdata (i_altitude),
        .i_raddr (alt_raddr),
        .o_rdata (alt_rdata)
    );

    tvc_ram #(.WIDTH(CNT_W), .DEPTH(DEPTH)) u_cnt_ram (
        .i_clk   (i_clk),
        .i_we    (cnt_we),
        .i_waddr (cnt_waddr),
        .i_wdata (cnt_wdata),
        .i_raddr (cnt_raddr),
        .o_rdata (cnt_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_cols <= GRID_COLS_RST;
            r_grid_rows <= GRID_ROWS_RST;
            r_radius    <= VIEW_RADIUS_RST;
            r_clr       <= '0;
            o_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_GRID_COLS:   r_grid_cols <= i_cfg_data;
                    CFG_GRID_ROWS:   r_grid_rows <= i_cfg_data;
                    CFG_VIEW_RADIUS: r_radius    <= i_cfg_data[7:0];
                    default: ;
                endcase
            end
            if (i_cmd == C_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
            if (i_cmd == C_OUT_LOAD) begin
                o_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd)
            C_ACCEPT: begin
                r_c0        <= i_col;
                r_r0        <= i_row;
                r_in_inside <= in_inside;
                r_resp_kind <= (i_command == CMD_READ);
            end
            C_SW_START: begin
                r_x    <= COORD_W'(r_c0) + 1'b1;
                r_y    <= COORD_W'(r_r0);
                r_xs   <= (r_c0 > r_radius) ? COORD_W'(r_c0 - r_radius) : '0;
                r_xe   <= (c0_plus < (COORD_W+1)'(cols_lim)) ? COORD_W'(c0_plus)
                                                             : COORD_W'(cols_lim);
                r_yend <= (r0_plus < (COORD_W+1)'(rows_lim)) ? COORD_W'(r0_plus)
                                                             : COORD_W'(rows_lim);
            end
            C_OBS_LATCH: r_a0 <= alt_rdata;
            C_ROW_NEXT: begin
                r_x <= r_xs;
                r_y <= r_y + 1'b1;
            end
            C_COL_NEXT: r_x <= r_x + 1'b1;
            C_TGT_LATCH: begin
                r_xmaj   <= ax > ay;
                r_major  <= (ax > ay) ? ax : ay;
                r_minor  <= (ax > ay) ? ay : ax;
                r_sx_neg <= dx < 0;
                r_sy_neg <= dy < 0;
                r_neg    <= rise < 0;
                r_mag    <= ALT_W'(rise < 0 ? -rise : rise);
            end
            C_SQ_INIT: begin
                r_sq_v   <= (SQ_W'(ax) * SQ_W'(ax) + SQ_W'(ay) * SQ_W'(ay)) << 16;
                r_sq_res <= '0;
                r_sq_bit <= SQ_W'(1) << 34;
                r_iter   <= '0;
            end
            C_SQ_STEP: begin
                if (r_sq_v >= sq_try) begin
                    r_sq_v   <= r_sq_v - sq_try;
                    r_sq_res <= (r_sq_res >> 1) + r_sq_bit;
                end else begin
                    r_sq_res <= r_sq_res >> 1;
                end
                r_sq_bit <= r_sq_bit >> 2;
                r_iter   <= r_iter + 1'b1;
            end
            C_DIV_INIT: begin
                r_q    <= (r_sq_res == '0) ? Q_W'(1) : r_sq_res[Q_W-1:0];
                r_dq   <= {r_mag, 24'd0};
                r_rem  <= '0;
                r_iter <= '0;
            end
            C_DIV_STEP: begin
                if (div_sh >= {1'b0, r_q}) begin
                    r_rem <= div_sh - {1'b0, r_q};
                    r_dq  <= {r_dq[QUO_W-2:0], 1'b1};
                end else begin
                    r_rem <= div_sh;
                    r_dq  <= {r_dq[QUO_W-2:0], 1'b0};
                end
                r_iter <= r_iter + 1'b1;
            end
            C_WALK_INIT: begin
                r_slope <= r_neg ? -$signed({2'b00, r_dq}) : $signed({2'b00, r_dq});
                r_lh    <= $signed({(LH_W-ALT_W-16)'(0), r_a0, 16'd0});
                r_p     <= $signed(P_W'({r_minor, 1'b0})) - $signed(P_W'(r_major));
                r_i     <= 8'd1;
                r_wx    <= COORD_W'(r_c0);
                r_wy    <= COORD_W'(r_r0);
            end
            C_STEP: begin
                if (r_p < 0) begin
                    r_p <= r_p + $signed(P_W'({r_minor, 1'b0}));
                end else begin
                    r_p <= r_p + $signed(P_W'({r_minor, 1'b0}))
                               - $signed(P_W'({r_major, 1'b0}));
                    if (r_xmaj) begin
                        r_wy <= r_sy_neg ? r_wy - 1'b1 : r_wy + 1'b1;
                    end else begin
                        r_wx <= r_sx_neg ? r_wx - 1'b1 : r_wx + 1'b1;
                    end
                end
                if (r_xmaj) begin
                    r_wx <= r_sx_neg ? r_wx - 1'b1 : r_wx + 1'b1;
                end else begin
                    r_wy <= r_sy_neg ? r_wy - 1'b1 : r_wy + 1'b1;
                end
                r_lh <= r_lh + r_slope;
                r_i  <= r_i + 1'b1;
            end
            C_RD_LATCH: r_resp_cnt <= r_in_inside ? cnt_rdata : '0;
            C_OUT_LOAD: begin
                o_kind  <= r_resp_kind;
                o_count <= r_resp_kind ? r_resp_cnt : '0;
            end
            default: ;
        endcase
    end

    assign o_stat.clr_last = (r_clr == AW'(DEPTH - 1));
    assign o_stat.obs_in   = (CFG_W'(r_c0) < cols_lim) && (CFG_W'(r_r0) < rows_lim);
    assign o_stat.row_done = (r_y >= r_yend);
    assign o_stat.col_done = (r_x >= r_xe);
    assign o_stat.sq_last  = (r_iter == ITER_W'(SQRT_ITERS - 1));
    assign o_stat.div_last = (r_iter == ITER_W'(QUO_W - 1));
    assign o_stat.walk_end = (r_i >= r_major);
    assign o_stat.blocked  = (wall >= r_lh);
    assign o_stat.out_free = !o_out_valid || !i_out_stall;

    a_out_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd == C_OUT_LOAD) |-> (!o_out_valid || !i_out_stall))
        else $error("result loaded over a held result");
    a_sq_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd == C_SQ_STEP) |-> (r_iter < ITER_W'(SQRT_ITERS)))
        else $error("square root ran past its iterations");
    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd == C_STEP) |-> (r_i < r_major))
        else $error("line walk reached the target cell");
    a_bump_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd == C_CNT_WR_OBS || i_cmd == C_CNT_WR_TGT) |-> (cnt_wdata != '0))
        else $error("count update wrote zero");
endmodule

// ===== rtl/core/terrain_viewshed_counter.sv =====
// ----------------------------------------------------------------------------
// Terrain viewshed counter
// Elevation grid with line-of-sight sweeps and per-cell visibility counts.
//
// Channel   Direction  Handshake                    Payload
// input     in         i_in_valid / o_in_stall      i_command, i_col, i_row, i_altitude
// output    out        o_out_valid / i_out_stall    o_kind, o_count
// config    in         i_cfg_we                     i_cfg_index, i_cfg_data
//
// Loads do not stall the input. A read passes through a read-wait state, where the
// count is latched, and a response state that loads the registered output.
// For each target a sweep runs the scan step, the 18-step square root and the
// 40-step slope divider, then the line walk (one altitude memory read per cell)
// and, for a visible target, the count updates of the observer and the target.
// After reset a clearing pass writes the count memory one entry per cycle, all
// MAX_COLS * MAX_ROWS entries, with the input stalled.
// Loads go on while a result is stalled; a read or sweep waits for its result.
// ----------------------------------------------------------------------------
module terrain_viewshed_counter
    import tvc_pkg::*;
#(
    parameter int MAX_COLS = MAX_COLS_DEF,
    parameter int MAX_ROWS = MAX_ROWS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [1:0]           i_command,
    input  logic [7:0]           i_col,
    input  logic [7:0]           i_row,
    input  logic [ALT_W-1:0]     i_altitude,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic                 o_kind,
    output logic [CNT_W-1:0]     o_count
);
    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    tvc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_command  (i_command),
        .o_in_stall (o_in_stall),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd)
    );

    tvc_dp #(.MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_command   (i_command),
        .i_col       (i_col),
        .i_row       (i_row),
        .i_altitude  (i_altitude),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_kind      (o_kind),
        .o_count     (o_count),
        .i_cmd       (dp_cmd),
        .o_stat      (dp_stat)
    );
endmodule

// ===== sim/terrain_viewshed_counter_chk.sv =====
// ----------------------------------------------------------------------------
// Terrain viewshed counter checker
// Watches the configuration port and both item channels, keeps its own copy
// of the elevation grid, the visibility counts and the registers, predicts
// the result of every accepted sweep and read and compares the results in order.
// ----------------------------------------------------------------------------
module terrain_viewshed_counter_chk
    import tvc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_in_valid,
    input  logic                 o_in_stall,
    input  logic [1:0]           i_command,
    input  logic [7:0]           i_col,
    input  logic [7:0]           i_row,
    input  logic [ALT_W-1:0]     i_altitude,
    input  logic                 o_out_valid,
    input  logic                 i_out_stall,
    input  logic                 o_kind,
    input  logic [CNT_W-1:0]     o_count,
    output int                   o_errors,
    output int                   o_pending
);

    localparam logic KIND_SWEEP_DONE = 1'b0;
    localparam logic KIND_READ       = 1'b1;
    localparam int   STORE_COLS      = 256;
    localparam int   STORE_ROWS      = 256;

    typedef struct packed {
        logic             kind;
        logic [CNT_W-1:0] count;
    } view_result_t;

    view_result_t     expected_q[$];
    logic [ALT_W-1:0] alt_mem [0:65535];
    logic [CNT_W-1:0] vis_count [0:65535];
    int               cols_cfg;
    int               rows_cfg;
    int               radius_cfg;

    initial begin
        for (int i = 0; i < 65536; i++) begin
            alt_mem[i] = '0;
            vis_count[i] = '0;
        end
        o_errors = 0;
        o_pending = 0;
    end

    function automatic longint unsigned floor_root(input longint unsigned v);
        longint unsigned res;
        longint unsigned bt;
        res = 0;
        bt = 64'd1 << 34;
        for (int i = 0; i < SQRT_ITERS; i++) begin
            if (v >= res + bt) begin
                v = v - (res + bt);
                res = (res >> 1) + bt;
            end else begin
                res = res >> 1;
            end
            bt = bt >> 2;
        end
        return res;
    endfunction

    function automatic int cell_at(input int c, input int r);
        return r * STORE_COLS + c;
    endfunction

    function automatic bit sightline_clear(input int x0, input int y0, input int x1, input int y1);
        int              dx, dy, ax, ay, sx, sy, a0, a1, rise, major, minor, p, x, y;
        bit              xmaj;
        longint unsigned mag, d_sq, q;
        longint          slope, height;
        dx = x1 - x0;
        dy = y1 - y0;
        ax = dx < 0 ? -dx : dx;
        ay = dy < 0 ? -dy : dy;
        sx = dx < 0 ? -1 : 1;
        sy = dy < 0 ? -1 : 1;
        a0 = int'(alt_mem[cell_at(x0, y0)]);
        a1 = int'(alt_mem[cell_at(x1, y1)]);
        rise = a1 - a0;
        mag = longint'(rise < 0 ? -rise : rise);
        d_sq = longint'(ax * ax + ay * ay);
        q = floor_root(d_sq << 16);
        if (q == 0) q = 1;
        slope = longint'((mag << 24) / q);
        if (rise < 0) slope = -slope;
        height = longint'(a0) * 65536;
        xmaj = ax > ay;
        major = xmaj ? ax : ay;
        minor = xmaj ? ay : ax;
        p = 2 * minor - major;
        x = x0;
        y = y0;
        for (int i = 1; i < major; i++) begin
            if (p < 0) begin
                p = p + 2 * minor;
            end else begin
                if (xmaj) y = y + sy; else x = x + sx;
                p = p + 2 * minor - 2 * major;
            end
            if (xmaj) x = x + sx; else y = y + sy;
            height = height + slope;
            if (longint'(alt_mem[cell_at(x, y)]) * 65536 >= height) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic void bump_count(input int idx);
        if (vis_count[idx] != '1) vis_count[idx] = vis_count[idx] + 1;
    endfunction

    function automatic void run_sweep(input int c0, input int r0);
        int cols, rows, yend, xs, xe;
        cols = cols_cfg < STORE_COLS ? cols_cfg : STORE_COLS;
        rows = rows_cfg < STORE_ROWS ? rows_cfg : STORE_ROWS;
        if (c0 >= cols || r0 >= rows) return;
        yend = r0 + radius_cfg < rows ? r0 + radius_cfg : rows;
        xs = c0 - radius_cfg > 0 ? c0 - radius_cfg : 0;
        xe = c0 + radius_cfg + 1 < cols ? c0 + radius_cfg + 1 : cols;
        for (int y = r0; y < yend; y++) begin
            for (int x = xs; x < xe; x++) begin
                if (!(y == r0 && x <= c0) && sightline_clear(c0, r0, x, y)) begin
                    bump_count(cell_at(c0, r0));
                    bump_count(cell_at(x, y));
                end
            end
        end
    endfunction

    always @(posedge i_clk) begin
        view_result_t want;
        if (!i_rst_n) begin
            cols_cfg = int'(GRID_COLS_RST);
            rows_cfg = int'(GRID_ROWS_RST);
            radius_cfg = int'(VIEW_RADIUS_RST);
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_GRID_COLS:   cols_cfg = int'(i_cfg_data);
                    CFG_GRID_ROWS:   rows_cfg = int'(i_cfg_data);
                    CFG_VIEW_RADIUS: radius_cfg = int'(i_cfg_data[7:0]);
                    default: ;
                endcase
            end
            if (o_out_valid && !i_out_stall) begin
                if (expected_q.size() == 0) begin
                    $display("%0t: unexpected result kind %0d count %0d", $time, o_kind,
                             o_count);
                    o_errors = o_errors + 1;
                end else begin
                    want = expected_q.pop_front();
                    if (want.kind !== o_kind) begin
                        $display("%0t: kind expected %0d actual %0d", $time, want.kind,
                                 o_kind);
                        o_errors = o_errors + 1;
                    end
                    if (want.count !== o_count) begin
                        $display("%0t: count expected %0d actual %0d", $time, want.count,
                                 o_count);
                        o_errors = o_errors + 1;
                    end
                end
            end
            if (i_in_valid && !o_in_stall) begin
                case (i_command)
                    CMD_LOAD: alt_mem[cell_at(i_col, i_row)] = i_altitude;
                    CMD_SWEEP: begin
                        run_sweep(int'(i_col), int'(i_row));
                        expected_q.push_back('{KIND_SWEEP_DONE, '0});
                    end
                    CMD_READ: expected_q.push_back('{KIND_READ, vis_count[cell_at(i_col, i_row)]});
                    default: ;
                endcase
            end
            o_pending = expected_q.size();
        end
    end

endmodule

// ===== sim/terrain_viewshed_counter_tb.sv =====
// ----------------------------------------------------------------------------
// Terrain viewshed counter testbench
// Loads elevation cells, runs observer sweeps and reads counts under several
// grid and radius settings, with random gaps on the input and random stalls
// on the output. A checker beside the block predicts and compares results.
// ----------------------------------------------------------------------------
module terrain_viewshed_counter_tb;
    import tvc_pkg::*;

    localparam logic [1:0]           CMD_UNUSED  = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED  = 2'd3;
    localparam int                   IDLE_LIMIT  = 500000;
    localparam int                   N_PHASES    = 8;
    localparam int                   N_PER_PHASE = 4;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0]     i_cfg_data;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic [1:0]           i_command;
    logic [7:0]           i_col;
    logic [7:0]           i_row;
    logic [ALT_W-1:0]     i_altitude;
    logic                 o_out_valid;
    logic                 i_out_stall;
    logic                 o_kind;
    logic [CNT_W-1:0]     o_count;
    int                   errors;
    int                   pending;
    int                   idle_cycles;
    bit                   calm;
    bit                   alt_known [0:65535];
    int                   g_cols;
    int                   g_rows;
    int                   g_rad;

    terrain_viewshed_counter uut (.*);

    terrain_viewshed_counter_chk chk (
        .*,
        .o_errors (errors),
        .o_pending(pending)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        i_out_stall <= !calm && ($urandom_range(99) < 18);
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("terrain_viewshed_counter_tb NOT OK");
            $finish;
        end
    end

    task automatic push_item(input logic [1:0] cmd, input logic [7:0] c, input logic [7:0] r,
                             input logic [ALT_W-1:0] a);
        while (!calm && $urandom_range(99) < 18) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_command <= cmd;
        i_col <= c;
        i_row <= r;
        i_altitude <= a;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    function automatic logic [ALT_W-1:0] pick_altitude();
        case ($urandom_range(3))
            0: return ALT_W'($urandom_range(65535));
            1: return $urandom_range(1) ? '1 : '0;
            default: return ALT_W'(1000 + $urandom_range(400));
        endcase
    endfunction

    task automatic load_cell(input int c, input int r, input logic [ALT_W-1:0] a);
        alt_known[r * 256 + c] = 1'b1;
        push_item(CMD_LOAD, 8'(c), 8'(r), a);
    endtask

    task automatic sweep_from(input int c0, input int r0);
        int cols, rows, yend, xs, xe;
        cols = g_cols < 256 ? g_cols : 256;
        rows = g_rows < 256 ? g_rows : 256;
        if (c0 < cols && r0 < rows) begin
            yend = r0 + g_rad < rows ? r0 + g_rad : rows;
            xs = c0 - g_rad > 0 ? c0 - g_rad : 0;
            xe = c0 + g_rad + 1 < cols ? c0 + g_rad + 1 : cols;
            for (int y = r0; y < yend; y++) begin
                for (int x = xs; x < xe; x++) begin
                    if (!alt_known[y * 256 + x]) load_cell(x, y, pick_altitude());
                end
            end
        end
        push_item(CMD_SWEEP, 8'(c0), 8'(r0), ALT_W'($urandom));
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic set_grid(input int cols, input int rows, input int rad);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_index <= CFG_GRID_COLS;
        i_cfg_data <= CFG_W'(cols);
        @(posedge i_clk);
        i_cfg_index <= CFG_GRID_ROWS;
        i_cfg_data <= CFG_W'(rows);
        @(posedge i_clk);
        i_cfg_index <= CFG_VIEW_RADIUS;
        i_cfg_data <= CFG_W'(rad);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        g_cols = cols;
        g_rows = rows;
        g_rad = rad;
    endtask

    function automatic int pick_coord(input int lim);
        if (lim == 0 || $urandom_range(9) == 0) return $urandom_range(255);
        return $urandom_range((lim < 256 ? lim : 256) - 1);
    endfunction

    task automatic random_item();
        int k;
        k = $urandom_range(99);
        if (k < 25) begin
            load_cell(pick_coord(g_cols), pick_coord(g_rows), pick_altitude());
        end else if (k < 55) begin
            sweep_from(pick_coord(g_cols), pick_coord(g_rows));
        end else if (k < 95) begin
            push_item(CMD_READ, 8'(pick_coord(g_cols)), 8'(pick_coord(g_rows)),
                      ALT_W'($urandom));
        end else begin
            push_item(CMD_UNUSED, 8'($urandom), 8'($urandom), ALT_W'($urandom));
        end
    endtask

    initial begin
        int ph_cols [N_PHASES] = '{256, 511, 1, 6, 16, 0, 9, 7};
        int ph_rows [N_PHASES] = '{256, 300, 1, 4, 16, 5, 256, 0};
        int ph_rad  [N_PHASES] = '{1, 2, 5, 255, 2, 4, 0, 2};
        for (int i = 0; i < 65536; i++) alt_known[i] = 1'b0;
        calm = 1'b0;
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_index <= CFG_GRID_COLS;
        i_cfg_data <= '0;
        i_in_valid <= 1'b0;
        i_command <= CMD_LOAD;
        i_col <= '0;
        i_row <= '0;
        i_altitude <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= CFG_UNUSED;
        i_cfg_data <= '1;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        set_grid(5, 3, 255);

        load_cell(255, 255, '1);
        push_item(CMD_READ, 8'd255, 8'd255, '0);
        push_item(CMD_UNUSED, 8'hAA, 8'h55, 16'h5A5A);
        load_cell(0, 0, '0);
        load_cell(2, 0, '1);
        load_cell(1, 1, 16'd1200);
        sweep_from(200, 3);
        sweep_from(0, 0);
        sweep_from(3, 0);
        sweep_from(7, 7);
        sweep_from(4, 2);
        push_item(CMD_READ, 8'd0, 8'd0, '0);
        push_item(CMD_READ, 8'd3, 8'd0, '0);
        push_item(CMD_READ, 8'd5, 8'd2, '0);
        push_item(CMD_READ, 8'd7, 8'd7, '0);
        push_item(CMD_READ, 8'd4, 8'd2, '0);

        for (int ph = 0; ph < N_PHASES; ph++) begin
            set_grid(ph_cols[ph], ph_rows[ph], ph_rad[ph]);
            calm = (ph == 3 || ph == 4);
            for (int n = 0; n < N_PER_PHASE; n++) random_item();
            calm = 1'b0;
        end
        drain();

        if (errors == 0) begin
            $display("terrain_viewshed_counter_tb OK");
        end else begin
            $display("terrain_viewshed_counter_tb NOT OK");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/tvc_pkg.sv
rtl/core/tvc_ram.sv
rtl/core/tvc_ctrl.sv
rtl/core/tvc_dp.sv
rtl/core/terrain_viewshed_counter.sv
sim/terrain_viewshed_counter_chk.sv
sim/terrain_viewshed_counter_tb.sv
